// ===== sv/sfd_pkg.sv =====
// shared types and constants of the serial frame deframer
package sfd_pkg;

    // payload store depth and derived address width
    localparam int MAX_DATA   = 32;
    localparam int ADDR_W     = $clog2(MAX_DATA);
    localparam int RESULT_CAP = 32;
    localparam int LIMIT_CAP  = (MAX_DATA < RESULT_CAP) ? MAX_DATA : RESULT_CAP;

    // frame layout
    localparam int MIN_TOTAL = 5;
    localparam int OVERHEAD  = 4;
    localparam int DATA_OFS  = 3;

    // register reset values
    localparam logic [7:0] HEAD_RESET = 8'hAA;
    localparam logic [7:0] TAIL_RESET = 8'h0D;
    localparam logic [5:0] MAXP_RESET = 6'd32;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXP = 2'd2;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_LENGTH   = 3'd1,
        ST_HEAD     = 3'd2,
        ST_TAIL     = 3'd3,
        ST_CHECKSUM = 3'd4
    } status_t;

    // live configuration
    typedef struct packed {
        logic [7:0] head_byte;
        logic [7:0] tail_byte;
        logic [5:0] max_payload;
    } cfg_t;

    // write into the payload store
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } store_wr_t;

    // frame verdict handed to the emitter at the final word
    typedef struct packed {
        logic       start;
        status_t    status;
        logic [7:0] command;
        logic [5:0] count;
    } job_t;

endpackage

// ===== sv/sfd_in_if.sv =====
// input byte channel
interface sfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       buffer_end;

    modport source (output valid, output rx_byte, output buffer_end, input ready);
    modport sink (input valid, input rx_byte, input buffer_end, output ready);
endinterface

// ===== sv/sfd_out_if.sv =====
// result channel
interface sfd_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] command;
    logic [5:0] payload_len;
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic       last_result;

    modport source (output valid, output status, output command, output payload_len,
                    output payload_byte, output byte_valid, output last_result,
                    input ready);
    modport sink (input valid, input status, input command, input payload_len,
                  input payload_byte, input byte_valid, input last_result,
                  output ready);
endinterface

// ===== sv/sfd_cfg_if.sv =====
// configuration write channel
interface sfd_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/serial_frame_deframer_core.sv =====
// top level of the serial frame deframer
//
// in_ch takes the raw bytes of one received buffer, one word per handshake,
// with buffer_end set on the final byte. Non-final words are accepted and
// produce no result. The final word closes the frame: the
// block checks length, head, tail, length field, total and XOR checksum.
// A good frame yields one out_ch word per data byte, carrying the command
// and data length, last_result set on the final one; an empty frame or a
// failed one yields a single word with last_result set.
// The first result is shown in the cycle after the final byte for an error
// or an empty frame; otherwise the sequencer first passes the fetch and load
// states. Each data byte then goes through a store read, an output load and
// the handshake, in turn, over the single read port of the payload store.
// in_ch is held off while results of a frame are pending; a stall on out_ch
// holds the current result word and stops the sequence.
// cfg_ch writes head_byte (index 0), tail_byte (1) and max_payload (2); it is
// always ready, other indexes are ignored. Reset restores the default
// registers (0xAA, 0x0D, 32) and clears the frame state; the payload store
// needs no clearing.
module serial_frame_deframer_core (
    input  logic       clk,
    input  logic       rst_n,
    sfd_in_if.sink     in_ch,
    sfd_out_if.source  out_ch,
    sfd_cfg_if.sink    cfg_ch
);
    import sfd_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    store_wr_t  store_wr;
    job_t       job;
    logic       emit_idle;
    logic       in_fire;

    // configuration registers
    assign cfg_ch.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_ch.valid)
        begin
            unique case (cfg_ch.index)
                CFG_HEAD: cfg_next.head_byte   = cfg_ch.data;
                CFG_TAIL: cfg_next.tail_byte   = cfg_ch.data;
                CFG_MAXP: cfg_next.max_payload = cfg_ch.data[5:0];
                default:  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.head_byte   <= HEAD_RESET;
            cfg_reg.tail_byte   <= TAIL_RESET;
            cfg_reg.max_payload <= MAXP_RESET;
        end
        else
            cfg_reg <= cfg_next;
    end

    // input accepted only while no results are pending
    assign in_ch.ready = emit_idle;
    assign in_fire     = in_ch.valid && emit_idle;

    sfd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .rx_byte    (in_ch.rx_byte),
        .buffer_end (in_ch.buffer_end),
        .cfg        (cfg_reg),
        .store_wr   (store_wr),
        .job        (job)
    );

    sfd_emitter u_emitter (
        .clk      (clk),
        .rst_n    (rst_n),
        .store_wr (store_wr),
        .job      (job),
        .idle     (emit_idle),
        .out_ch   (out_ch)
    );

endmodule

// ===== sv/sfd_parser.sv =====
// frame parser: per-buffer state, store writes and end-of-buffer verdict
module sfd_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  logic [7:0]          rx_byte,
    input  logic                buffer_end,
    input  sfd_pkg::cfg_t       cfg,
    output sfd_pkg::store_wr_t  store_wr,
    output sfd_pkg::job_t       job
);
    import sfd_pkg::*;

    logic [5:0] byte_count_reg, byte_count_next;
    logic       head_ok_reg, head_ok_next;
    logic [7:0] length_reg, length_next;
    logic [7:0] command_reg, command_next;
    logic [7:0] xor_reg, xor_next;
    logic [7:0] near_reg, near_next;

    logic [5:0] limit;
    logic [8:0] total_w;
    logic [8:0] len_w;
    status_t    verdict;

    // effective data length limit
    assign limit = ({2'b00, cfg.max_payload} > 8'(LIMIT_CAP)) ? 6'(LIMIT_CAP)
                                                              : cfg.max_payload;
    assign total_w = 9'(byte_count_reg) + 9'd1;
    assign len_w   = {1'b0, length_reg};

    // checks in priority order
    always_comb
    begin
        priority if (total_w < 9'(MIN_TOTAL))
            verdict = ST_LENGTH;
        else if (!head_ok_reg)
            verdict = ST_HEAD;
        else if (rx_byte != cfg.tail_byte)
            verdict = ST_TAIL;
        else if ((len_w < 9'd1) || (len_w > 9'(limit) + 9'd1))
            verdict = ST_LENGTH;
        else if (total_w != len_w + 9'(OVERHEAD))
            verdict = ST_LENGTH;
        else if ((xor_reg ^ near_reg) != near_reg)
            verdict = ST_CHECKSUM;
        else
            verdict = ST_OK;
    end

    // verdict out to the emitter
    always_comb
    begin
        job.start   = in_fire && buffer_end;
        job.status  = verdict;
        job.command = command_reg;
        job.count   = 6'(length_reg - 8'd1);
    end

    // store write for data-area words
    always_comb
    begin
        store_wr.en   = in_fire && !buffer_end && (byte_count_reg >= 6'(DATA_OFS))
                        && ({1'b0, byte_count_reg} < 7'(MAX_DATA + DATA_OFS));
        store_wr.addr = ADDR_W'(byte_count_reg - 6'(DATA_OFS));
        store_wr.data = rx_byte;
    end

    // per-buffer state update
    always_comb
    begin
        byte_count_next = byte_count_reg;
        head_ok_next    = head_ok_reg;
        length_next     = length_reg;
        command_next    = command_reg;
        xor_next        = xor_reg;
        near_next       = near_reg;
        if (in_fire)
        begin
            if (buffer_end)
            begin
                byte_count_next = '0;
                head_ok_next    = 1'b0;
                length_next     = '0;
                command_next    = '0;
                xor_next        = '0;
                near_next       = '0;
            end
            else
            begin
                if (byte_count_reg == 6'd0)
                    head_ok_next = (rx_byte == cfg.head_byte);
                else
                    xor_next = xor_reg ^ rx_byte;
                if (byte_count_reg == 6'd1)
                    length_next = rx_byte;
                if (byte_count_reg == 6'd2)
                    command_next = rx_byte;
                near_next = rx_byte;
                if (byte_count_reg != 6'h3F)
                    byte_count_next = byte_count_reg + 6'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            head_ok_reg    <= 1'b0;
            length_reg     <= '0;
            command_reg    <= '0;
            xor_reg        <= '0;
            near_reg       <= '0;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
            head_ok_reg    <= head_ok_next;
            length_reg     <= length_next;
            command_reg    <= command_next;
            xor_reg        <= xor_next;
            near_reg       <= near_next;
        end
    end

endmodule

// ===== sv/sfd_emitter.sv =====
// payload store and result sequencer with output register
module sfd_emitter (
    input  logic                clk,
    input  logic                rst_n,
    input  sfd_pkg::store_wr_t  store_wr,
    input  sfd_pkg::job_t       job,
    output logic                idle,
    sfd_out_if.source           out_ch
);
    import sfd_pkg::*;

    typedef enum logic [3:0] {
        E_IDLE  = 4'b0001,
        E_FETCH = 4'b0010,
        E_LOAD  = 4'b0100,
        E_SHOW  = 4'b1000
    } emit_state_t;

    emit_state_t state_reg, state_next;
    logic [5:0]  k_reg, k_next;
    logic [5:0]  n_reg, n_next;
    logic [7:0]  cmd_reg, cmd_next;

    status_t     o_status_reg, o_status_next;
    logic [7:0]  o_cmd_reg, o_cmd_next;
    logic [5:0]  o_len_reg, o_len_next;
    logic [7:0]  o_byte_reg, o_byte_next;
    logic        o_bv_reg, o_bv_next;
    logic        o_last_reg, o_last_next;

    logic [7:0]  mem [MAX_DATA];
    logic [7:0]  rd_data_reg;
    logic        rd_en;

    // payload store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (store_wr.en)
            mem[store_wr.addr] <= store_wr.data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[k_reg[ADDR_W-1:0]];
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        k_next        = k_reg;
        n_next        = n_reg;
        cmd_next      = cmd_reg;
        o_status_next = o_status_reg;
        o_cmd_next    = o_cmd_reg;
        o_len_next    = o_len_reg;
        o_byte_next   = o_byte_reg;
        o_bv_next     = o_bv_reg;
        o_last_next   = o_last_reg;
        rd_en         = 1'b0;
        unique case (state_reg)
            E_IDLE:
            begin
                if (job.start)
                begin
                    k_next   = '0;
                    n_next   = job.count;
                    cmd_next = job.command;
                    if (job.status != ST_OK)
                    begin
                        o_status_next = job.status;
                        o_cmd_next    = '0;
                        o_len_next    = '0;
                        o_byte_next   = '0;
                        o_bv_next     = 1'b0;
                        o_last_next   = 1'b1;
                        state_next    = E_SHOW;
                    end
                    else if (job.count == 6'd0)
                    begin
                        o_status_next = ST_OK;
                        o_cmd_next    = job.command;
                        o_len_next    = '0;
                        o_byte_next   = '0;
                        o_bv_next     = 1'b0;
                        o_last_next   = 1'b1;
                        state_next    = E_SHOW;
                    end
                    else
                        state_next = E_FETCH;
                end
            end
            E_FETCH:
            begin
                rd_en      = 1'b1;
                state_next = E_LOAD;
            end
            E_LOAD:
            begin
                o_status_next = ST_OK;
                o_cmd_next    = cmd_reg;
                o_len_next    = n_reg;
                o_byte_next   = rd_data_reg;
                o_bv_next     = 1'b1;
                o_last_next   = (k_reg + 6'd1 == n_reg);
                state_next    = E_SHOW;
            end
            E_SHOW:
            begin
                if (out_ch.ready)
                begin
                    if (o_last_reg)
                        state_next = E_IDLE;
                    else
                    begin
                        k_next     = k_reg + 6'd1;
                        state_next = E_FETCH;
                    end
                end
            end
            default:
                state_next = E_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            k_reg     <= '0;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            n_reg     <= n_next;
        end
    end

    // output word register
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        o_status_reg <= o_status_next;
        o_cmd_reg    <= o_cmd_next;
        o_len_reg    <= o_len_next;
        o_byte_reg   <= o_byte_next;
        o_bv_reg     <= o_bv_next;
        o_last_reg   <= o_last_next;
    end

    assign idle                = (state_reg == E_IDLE);
    assign out_ch.valid        = (state_reg == E_SHOW);
    assign out_ch.status       = o_status_reg;
    assign out_ch.command      = o_cmd_reg;
    assign out_ch.payload_len  = o_len_reg;
    assign out_ch.payload_byte = o_byte_reg;
    assign out_ch.byte_valid   = o_bv_reg;
    assign out_ch.last_result  = o_last_reg;

endmodule

// ===== dv/sfd_frame_check_pkg.sv =====
// predictor and result checker for the serial frame deframer testbench
package sfd_frame_check_pkg;

    import sfd_pkg::*;

    // one result word as seen on the output channel
    typedef struct packed {
        status_t    status;
        logic [7:0] command;
        logic [5:0] payload_len;
        logic [7:0] payload_byte;
        logic       byte_valid;
        logic       last_result;
    } deframe_word_t;

    class frame_checker;

        // register mirror
        logic [7:0] head_val;
        logic [7:0] tail_val;
        logic [5:0] max_data;

        // frame being collected
        logic [5:0] seen;
        logic       head_match;
        logic [7:0] len_byte;
        logic [7:0] cmd_byte;
        logic [7:0] xor_acc;
        logic [7:0] data_buf [MAX_DATA];

        deframe_word_t expected_words[$];
        int fails;
        int shown;

        function new();
            head_val = HEAD_RESET;
            tail_val = TAIL_RESET;
            max_data = MAXP_RESET;
            fails = 0;
            shown = 0;
            restart();
        endfunction

        function void restart();
            seen = '0;
            head_match = 1'b0;
            len_byte = '0;
            cmd_byte = '0;
            xor_acc = '0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
            case (idx)
                CFG_HEAD: head_val = val;
                CFG_TAIL: tail_val = val;
                CFG_MAXP: max_data = val[5:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        // note one accepted input word and queue the words it causes
        function void take_byte(logic [7:0] b, logic fin);
            int pos;
            int total;
            int lim;
            int len;
            status_t verdict;
            deframe_word_t w;
            pos = seen;
            if (!fin)
            begin
                if (pos == 0)
                    head_match = (b == head_val);
                else
                    xor_acc = xor_acc ^ b;
                if (pos == 1)
                    len_byte = b;
                if (pos == 2)
                    cmd_byte = b;
                if (pos >= DATA_OFS && pos - DATA_OFS < MAX_DATA)
                    data_buf[pos - DATA_OFS] = b;
                // count saturates at the top of its range
                if (seen != 6'h3F)
                    seen = seen + 6'd1;
            end
            else
            begin
                total = pos + 1;
                lim = (max_data > LIMIT_CAP) ? LIMIT_CAP : int'(max_data);
                len = len_byte;
                verdict = ST_OK;
                // xor over length .. checksum byte is zero for a good checksum
                if (total < MIN_TOTAL)
                    verdict = ST_LENGTH;
                else if (!head_match)
                    verdict = ST_HEAD;
                else if (b != tail_val)
                    verdict = ST_TAIL;
                else if (len < 1 || len > lim + 1)
                    verdict = ST_LENGTH;
                else if (total != len + OVERHEAD)
                    verdict = ST_LENGTH;
                else if (xor_acc != 8'h00)
                    verdict = ST_CHECKSUM;

                w.status = verdict;
                w.command = 8'h00;
                w.payload_len = 6'd0;
                w.payload_byte = 8'h00;
                w.byte_valid = 1'b0;
                w.last_result = 1'b1;
                if (verdict != ST_OK)
                    expected_words.push_back(w);
                else if (len == 1)
                begin
                    // empty data: one word with the command only
                    w.command = cmd_byte;
                    expected_words.push_back(w);
                end
                else
                begin
                    for (int k = 0; k < len - 1; k++)
                    begin
                        w.command = cmd_byte;
                        w.payload_len = 6'(len - 1);
                        w.payload_byte = data_buf[k];
                        w.byte_valid = 1'b1;
                        w.last_result = (k == len - 2);
                        expected_words.push_back(w);
                    end
                end
                restart();
            end
        endfunction

        // compare one accepted output word with the oldest expectation
        function void match_word(deframe_word_t got);
            deframe_word_t want;
            if (expected_words.size() == 0)
            begin
                fails++;
                if (shown < 10)
                begin
                    $display("unexpected word: st=%0d cmd=%02h len=%0d byte=%02h bv=%0b last=%0b",
                             got.status, got.command, got.payload_len, got.payload_byte,
                             got.byte_valid, got.last_result);
                    shown++;
                end
            end
            else
            begin
                want = expected_words.pop_front();
                if (got.status !== want.status || got.command !== want.command ||
                    got.payload_len !== want.payload_len ||
                    got.payload_byte !== want.payload_byte ||
                    got.byte_valid !== want.byte_valid ||
                    got.last_result !== want.last_result)
                begin
                    fails++;
                    if (shown < 10)
                    begin
                        $display("mismatch: exp st=%0d cmd=%02h len=%0d byte=%02h bv=%0b last=%0b",
                                 want.status, want.command, want.payload_len,
                                 want.payload_byte, want.byte_valid, want.last_result);
                        $display("          got st=%0d cmd=%02h len=%0d byte=%02h bv=%0b last=%0b",
                                 got.status, got.command, got.payload_len,
                                 got.payload_byte, got.byte_valid, got.last_result);
                        shown++;
                    end
                end
            end
        endfunction

    endclass

endpackage

// ===== dv/tb_serial_frame_deframer_core.sv =====
// testbench top of the serial frame deframer: framed byte stimulus, checked result words
module tb_serial_frame_deframer_core;

    import sfd_pkg::*;
    import sfd_frame_check_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int PHASE_BYTES = 22;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES = 400;
    localparam int LIMIT_TIME = 40_000_000;

    // kinds of generated buffers
    typedef enum int {
        BUF_GOOD,
        BUF_BAD_HEAD,
        BUF_BAD_TAIL,
        BUF_BAD_SUM,
        BUF_BAD_LEN,
        BUF_BAD_TOTAL,
        BUF_SHORT,
        BUF_NOISE,
        BUF_LONG
    } buf_kind_t;

    logic clk;
    logic rst_n;

    sfd_in_if  in_ch();
    sfd_out_if out_ch();
    sfd_cfg_if cfg_ch();

    serial_frame_deframer_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    frame_checker  sb;
    deframe_word_t got_word;
    logic [7:0]    frame_bytes[$];
    int            src_idle_pct;
    int            sink_stall_pct;
    int            rx_hold_cycles;

    // clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // overall time limit
    initial
    begin
        #(LIMIT_TIME);
        $display("tb: failure");
        $finish;
    end

    // receiver ready, with random stalls and a counted hold-off
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_cycles > 0)
            begin
                out_ch.ready = 1'b0;
                rx_hold_cycles--;
            end
            else
                out_ch.ready = ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // sample both channels at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got_word.status = status_t'(out_ch.status);
                got_word.command = out_ch.command;
                got_word.payload_len = out_ch.payload_len;
                got_word.payload_byte = out_ch.payload_byte;
                got_word.byte_valid = out_ch.byte_valid;
                got_word.last_result = out_ch.last_result;
                sb.match_word(got_word);
            end
            if (in_ch.valid && in_ch.ready)
                sb.take_byte(in_ch.rx_byte, in_ch.buffer_end);
        end
    end

    // offer one word, entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid = 1'b1;
        in_ch.rx_byte = b;
        in_ch.buffer_end = fin;
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
    endtask

    // send frame_bytes as one buffer, end flag on the last word
    task automatic send_buffer();
        for (int i = 0; i < frame_bytes.size(); i++)
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data = val;
        do @(posedge clk); while (!cfg_ch.ready);
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // stop offering and wait until every expected word has arrived
    task automatic drain();
        in_ch.valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // fill frame_bytes with a buffer of the given kind under the current registers
    task automatic build_buffer(input buf_kind_t kind);
        int n;
        int lim;
        logic [7:0] len;
        logic [7:0] cmd;
        logic [7:0] sum;
        logic [7:0] d;
        frame_bytes.delete();
        lim = (sb.max_data > LIMIT_CAP) ? LIMIT_CAP : int'(sb.max_data);
        if (kind == BUF_SHORT || kind == BUF_NOISE)
        begin
            n = (kind == BUF_SHORT) ? $urandom_range(1, 4) : $urandom_range(5, 12);
            repeat (n)
            begin
                d = $urandom;
                frame_bytes.push_back(d);
            end
        end
        else
        begin
            n = ($urandom_range(0, 3) == 0) ? lim : $urandom_range(0, lim);
            len = 8'(n + 1);
            cmd = $urandom;
            sum = len ^ cmd;
            frame_bytes.push_back(sb.head_val);
            frame_bytes.push_back(len);
            frame_bytes.push_back(cmd);
            for (int i = 0; i < n; i++)
            begin
                d = $urandom;
                sum = sum ^ d;
                frame_bytes.push_back(d);
            end
            // total off by one word either way
            if (kind == BUF_BAD_TOTAL)
            begin
                if (n > 0 && $urandom_range(0, 1) == 1)
                    void'(frame_bytes.pop_back());
                else
                begin
                    d = $urandom;
                    frame_bytes.push_back(d);
                end
            end
            // pad past the saturation point of the word count
            if (kind == BUF_LONG)
            begin
                repeat ($urandom_range(60, 68))
                begin
                    d = $urandom;
                    frame_bytes.push_back(d);
                end
            end
            if (kind == BUF_BAD_LEN)
                frame_bytes[1] = ($urandom_range(0, 1) == 0) ? 8'h00 :
                                 8'($urandom_range(lim + 2, 255));
            if (kind == BUF_BAD_SUM)
                sum = sum ^ 8'($urandom_range(1, 255));
            frame_bytes.push_back(sum);
            if (kind == BUF_BAD_TAIL)
                frame_bytes.push_back(sb.tail_val ^ 8'($urandom_range(1, 255)));
            else
                frame_bytes.push_back(sb.tail_val);
            if (kind == BUF_BAD_HEAD)
                frame_bytes[0] = frame_bytes[0] ^ 8'($urandom_range(1, 255));
        end
    endtask

    function automatic buf_kind_t pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 58) return BUF_GOOD;
        if (r < 64) return BUF_BAD_HEAD;
        if (r < 70) return BUF_BAD_TAIL;
        if (r < 77) return BUF_BAD_SUM;
        if (r < 83) return BUF_BAD_LEN;
        if (r < 89) return BUF_BAD_TOTAL;
        if (r < 94) return BUF_SHORT;
        return BUF_NOISE;
    endfunction

    // main sequence
    initial
    begin
        int phase_bytes;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.rx_byte = 8'h00;
        in_ch.buffer_end = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_HEAD;
        cfg_ch.data = 8'h00;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        rx_hold_cycles = 0;
        sb = new();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: one-word buffer, empty frame, one data word, head and tail errors
        frame_bytes = '{8'h00};
        send_buffer();
        frame_bytes = '{8'hAA, 8'h01, 8'hFF, 8'hFE, 8'h0D};
        send_buffer();
        frame_bytes = '{8'hAA, 8'h02, 8'h00, 8'hFF, 8'hFD, 8'h0D};
        send_buffer();
        frame_bytes = '{8'h55, 8'h01, 8'h10, 8'h11, 8'h0D};
        send_buffer();
        frame_bytes = '{8'hAA, 8'h01, 8'h10, 8'h11, 8'h0C};
        send_buffer();

        for (int phase = 0; phase < 8; phase++)
        begin
            // register settings, written while the block is idle
            case (phase)
                1:
                begin
                    write_reg(CFG_HEAD, 8'h00);
                    write_reg(CFG_TAIL, 8'hFF);
                    write_reg(CFG_MAXP, 8'd0);
                end
                2:
                begin
                    write_reg(CFG_HEAD, 8'hFF);
                    write_reg(CFG_TAIL, 8'h00);
                    write_reg(CFG_MAXP, 8'd32);
                end
                3:
                begin
                    write_reg(CFG_HEAD, 8'($urandom));
                    write_reg(CFG_TAIL, 8'($urandom));
                    write_reg(CFG_MAXP, 8'd1);
                end
                4:
                begin
                    write_reg(CFG_HEAD, 8'($urandom));
                    write_reg(CFG_TAIL, 8'($urandom));
                    write_reg(CFG_MAXP, 8'($urandom_range(0, 32)));
                end
                5:
                begin
                    write_reg(CFG_SPARE, 8'($urandom));
                    write_reg(CFG_HEAD, 8'($urandom));
                    write_reg(CFG_TAIL, 8'($urandom));
                    write_reg(CFG_MAXP, 8'd63);
                end
                6:
                begin
                    write_reg(CFG_HEAD, HEAD_RESET);
                    write_reg(CFG_TAIL, TAIL_RESET);
                    write_reg(CFG_MAXP, 8'd5);
                end
                7:
                begin
                    write_reg(CFG_HEAD, 8'($urandom));
                    write_reg(CFG_TAIL, 8'($urandom));
                    write_reg(CFG_MAXP, 8'd32);
                end
                default: ;
            endcase

            // idle mode: none, sender, receiver, both
            case (phase % 4)
                0:
                begin
                    src_idle_pct = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct = 86;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct = 0;
                    sink_stall_pct = 86;
                end
                default:
                begin
                    src_idle_pct = 32;
                    sink_stall_pct = 32;
                end
            endcase

            // long receiver hold-off while the sender keeps offering
            if (phase == 4)
                rx_hold_cycles = HOLD_CYCLES;

            phase_bytes = 0;
            if (phase == 2)
            begin
                build_buffer(BUF_LONG);
                send_buffer();
                phase_bytes = frame_bytes.size();
            end
            while (phase_bytes < PHASE_BYTES)
            begin
                build_buffer(pick_kind());
                send_buffer();
                phase_bytes += frame_bytes.size();
            end
            drain();
        end

        repeat (20) @(posedge clk);
        if (sb.fails == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== serial_frame_deframer_core.f =====
sv/sfd_pkg.sv
sv/sfd_in_if.sv
sv/sfd_out_if.sv
sv/sfd_cfg_if.sv
sv/sfd_parser.sv
sv/sfd_emitter.sv
sv/serial_frame_deframer_core.sv
dv/sfd_frame_check_pkg.sv
dv/tb_serial_frame_deframer_core.sv
